// ===== rtl/core/int8_int4_dot_product_accumulator_macros.svh =====
// Assertion macros used by the dot product accumulator back end.
`ifndef INT8_INT4_DOT_PRODUCT_ACCUMULATOR_MACROS_SVH
`define INT8_INT4_DOT_PRODUCT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IDPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("idpa assertion failed");

// Next-cycle implication, checked out of reset.
`define IDPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("idpa assertion failed");

`endif

// ===== rtl/core/idpa_pkg.sv =====
// Shared types and constants for the dot product accumulator.
`default_nettype none
package idpa_pkg;

    localparam int BYTES_MAX          = 8;
    localparam int DEF_BYTES_PER_ITEM = 8;
    localparam int DEF_QUEUE_DEPTH    = 4;
    localparam int WORD_W             = 64;
    localparam int CNT_W              = 5;
    localparam int PROD_W             = 17;
    localparam int PSUM_W             = 20;
    localparam int ADDR_W             = 2;
    localparam int DATA_W             = 32;

    localparam logic [ADDR_W-1:0] REG_ELEMENT_FORMAT = 2'd0;
    localparam logic [7:0]        NIBBLE_MASK        = 8'h0F;

    typedef enum logic [0:0] {
        FMT_BYTE   = 1'b0,
        FMT_NIBBLE = 1'b1
    } t_fmt;

    typedef struct packed {
        logic [WORD_W-1:0]    a_word;
        logic [WORD_W-1:0]    b_word;
        logic [BYTES_MAX-1:0] lo_en;
        logic [BYTES_MAX-1:0] hi_en;
        t_fmt                 fmt;
        logic                 last;
    } t_item;

endpackage
`default_nettype wire

// ===== rtl/core/idpa_front.sv =====
// Front end: input register, count clamp and per-lane enable decode.
`default_nettype none
module idpa_front import idpa_pkg::*; #(
    parameter int BYTES_PER_ITEM = DEF_BYTES_PER_ITEM
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [WORD_W-1:0] i_a_word,
    input  wire logic [WORD_W-1:0] i_b_word,
    input  wire logic [CNT_W-1:0]  i_element_count,
    input  wire logic              i_is_last,
    input  wire t_fmt              i_fmt,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_item                  o_item
);

    logic             r_valid, n_valid;
    t_item            r_item, n_item;
    logic [CNT_W-1:0] w_lanes, w_cnt;
    logic             w_accept;

    assign o_in_ready = !r_valid || !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    assign w_lanes = (i_fmt == FMT_NIBBLE) ? CNT_W'(2 * BYTES_PER_ITEM)
                                           : CNT_W'(BYTES_PER_ITEM);
    assign w_cnt   = (i_element_count > w_lanes) ? w_lanes : i_element_count;

    always_comb begin
        n_item.a_word = i_a_word;
        n_item.b_word = i_b_word;
        n_item.fmt    = i_fmt;
        n_item.last   = i_is_last;
        n_item.lo_en  = '0;
        n_item.hi_en  = '0;
        for (int j = 0; j < BYTES_MAX; j++) begin
            if (j < BYTES_PER_ITEM) begin
                if (i_fmt == FMT_NIBBLE) begin
                    n_item.lo_en[j] = CNT_W'(2 * j) < w_cnt;
                    n_item.hi_en[j] = CNT_W'(2 * j + 1) < w_cnt;
                end else begin
                    n_item.lo_en[j] = CNT_W'(j) < w_cnt;
                end
            end
        end
    end

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/idpa_queue.sv =====
// Short register queue between front and back end.
`default_nettype none
module idpa_queue import idpa_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_head,
    output logic       o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_QW-1:0]  r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_QW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_QW'(1);
            2'b01:   n_cnt = r_cnt - CNT_QW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/idpa_back.sv =====
// Back end: lane multiply, reduction, 64-bit accumulate and result register.
`default_nettype none
`include "int8_int4_dot_product_accumulator_macros.svh"
module idpa_back import idpa_pkg::*; #(
    parameter int BYTES_PER_ITEM = DEF_BYTES_PER_ITEM
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_item               i_head,
    input  wire logic                i_q_empty,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [WORD_W-1:0] o_dot_sum
);

    logic                     w_adv;
    logic                     r_v1, r_last1, r_v2, r_last2;
    logic signed [PROD_W-1:0] r_prod [BYTES_MAX];
    logic signed [PROD_W-1:0] n_prod [BYTES_MAX];
    logic signed [PSUM_W-1:0] r_psum, n_psum;
    logic        [WORD_W-1:0] r_acc, n_sum;
    logic                     r_out_valid;
    logic        [WORD_W-1:0] r_out;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_pop       = w_adv && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_dot_sum   = $signed(r_out);

    // per-byte products; nibble mode folds both nibbles of a byte
    always_comb begin
        logic [7:0]               a8, b8, an;
        logic signed [PROD_W-1:0] pb, plo, phi;
        for (int j = 0; j < BYTES_MAX; j++) begin
            a8  = i_head.a_word[8*j +: 8];
            b8  = i_head.b_word[8*j +: 8];
            an  = (a8 >> 4) & NIBBLE_MASK;
            pb  = $signed({9'b0, a8}) * $signed({{9{b8[7]}}, b8});
            plo = $signed({9'b0, a8 & NIBBLE_MASK}) * $signed({{13{b8[3]}}, b8[3:0]});
            phi = $signed({9'b0, an}) * $signed({{13{b8[7]}}, b8[7:4]});
            n_prod[j] = '0;
            if (j < BYTES_PER_ITEM) begin
                if (i_head.fmt == FMT_NIBBLE) begin
                    n_prod[j] = (i_head.lo_en[j] ? plo : '0) + (i_head.hi_en[j] ? phi : '0);
                end else begin
                    n_prod[j] = i_head.lo_en[j] ? pb : '0;
                end
            end
        end
    end

    always_comb begin
        n_psum = '0;
        for (int j = 0; j < BYTES_MAX; j++) begin
            n_psum = n_psum + PSUM_W'(r_prod[j]);
        end
    end

    assign n_sum = r_acc + {{(WORD_W-PSUM_W){r_psum[PSUM_W-1]}}, r_psum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_out_valid <= r_v2 && r_last2;
            if (r_v2) begin
                r_acc <= r_last2 ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last1 <= i_head.last;
            r_prod  <= n_prod;
            r_last2 <= r_last1;
            r_psum  <= n_psum;
            if (r_v2 && r_last2) begin
                r_out <= n_sum;
            end
        end
    end

    `IDPA_ASSERT_NEXT(a_last_emits, r_v2 && r_last2 && w_adv, r_out_valid)
    `IDPA_ASSERT_NEXT(a_last_clears, r_v2 && r_last2 && w_adv, r_acc == '0)
    `IDPA_ASSERT_NEXT(a_stall_freeze, !w_adv, $stable(r_acc) && $stable(r_v2))

endmodule
`default_nettype wire

// ===== rtl/core/int8_int4_dot_product_accumulator.sv =====
// Top level: u8/s8 and u4/s4 streaming dot product accumulator with APB config.
//
//  channel   dir  handshake                     payload
//  input     in   i_in_valid / o_in_ready       i_a_word i_b_word i_element_count i_is_last
//  output    out  o_out_valid / i_out_ready     o_dot_sum
//  config    in   psel penable pwrite / pready  paddr pwdata prdata
//
// One transaction per cycle sustained unless the output stalls; the lane multipliers and
// adder tree are pipelined behind the input register and the queue.
// Synchronous reset clears the sum, all valid flags and selects byte format.
// An output stall freezes the back end; the queue and input register then fill
// and o_in_ready drops.
`default_nettype none
module int8_int4_dot_product_accumulator import idpa_pkg::*; #(
    parameter int BYTES_PER_ITEM = DEF_BYTES_PER_ITEM,
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [WORD_W-1:0]   i_a_word,
    input  wire logic [WORD_W-1:0]   i_b_word,
    input  wire logic [CNT_W-1:0]    i_element_count,
    input  wire logic                i_is_last,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [WORD_W-1:0] o_dot_sum,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    t_fmt  r_fmt;
    logic  w_push, w_pop, w_full, w_empty;
    t_item w_push_item, w_head;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ELEMENT_FORMAT) ? {{(DATA_W-1){1'b0}}, r_fmt} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_BYTE;
        end else if (psel && penable && pwrite && pready && paddr == REG_ELEMENT_FORMAT) begin
            r_fmt <= t_fmt'(pwdata[0]);
        end
    end

    idpa_front #(
        .BYTES_PER_ITEM(BYTES_PER_ITEM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_a_word       (i_a_word),
        .i_b_word       (i_b_word),
        .i_element_count(i_element_count),
        .i_is_last      (i_is_last),
        .i_fmt          (r_fmt),
        .i_q_full       (w_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    idpa_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_push_item),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_empty(w_empty)
    );

    idpa_back #(
        .BYTES_PER_ITEM(BYTES_PER_ITEM)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_empty  (w_empty),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_dot_sum  (o_dot_sum)
    );

endmodule
`default_nettype wire

// ===== sim/int8_int4_dot_product_accumulator_tb.sv =====
// Testbench for the u8/s8 and u4/s4 streaming dot product accumulator.
module int8_int4_dot_product_accumulator_tb;
    import idpa_pkg::*;

    localparam int LANE_BYTES   = DEF_BYTES_PER_ITEM;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 12;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 150;

    typedef struct {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [CNT_W-1:0]  cnt;
        logic              last;
        int                gap;
    } t_operand_pair;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [WORD_W-1:0]        i_a_word = '0;
    logic [WORD_W-1:0]        i_b_word = '0;
    logic [CNT_W-1:0]         i_element_count = '0;
    logic                     i_is_last = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [WORD_W-1:0] o_dot_sum;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    t_operand_pair pairs_to_send[$];
    longint        sums_due[$];
    t_fmt          fmt_cfg = FMT_BYTE;
    longint        vector_sum = 0;
    int            errors = 0;
    int            cycles = 0;
    int            tx_mode = 1;
    int            rx_mode = 1;
    int            hold_asks = 0;
    logic          in_taken = 1'b0;
    logic          out_taken = 1'b0;
    logic          tx_busy = 1'b0;
    logic          offering = 1'b0;

    int8_int4_dot_product_accumulator #(
        .BYTES_PER_ITEM(LANE_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_a_word       (i_a_word),
        .i_b_word       (i_b_word),
        .i_element_count(i_element_count),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_dot_sum      (o_dot_sum),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint pair_dot(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                        input logic [CNT_W-1:0] cnt, input t_fmt f);
        int     lanes;
        int     n;
        longint acc;
        logic [3:0] an;
        logic [3:0] bn;
        lanes = (f == FMT_NIBBLE) ? 2 * LANE_BYTES : LANE_BYTES;
        n = (int'(cnt) > lanes) ? lanes : int'(cnt);
        acc = 0;
        for (int k = 0; k < n; k++) begin
            if (f == FMT_NIBBLE) begin
                an = a[8 * (k / 2) + 4 * (k % 2) +: 4];
                bn = b[8 * (k / 2) + 4 * (k % 2) +: 4];
                acc = acc + longint'(an) * longint'($signed(bn));
            end else begin
                acc = acc + longint'(a[8 * k +: 8]) * longint'($signed(b[8 * k +: 8]));
            end
        end
        return acc;
    endfunction

    function automatic int draw_wait(input int mode);
        if (mode == 0) begin
            return 0;
        end else if (mode == 1) begin
            return $urandom_range(0, 18);
        end
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [CNT_W-1:0] pick_count(input t_fmt f);
        int lanes;
        int r;
        lanes = (f == FMT_NIBBLE) ? 2 * LANE_BYTES : LANE_BYTES;
        r = $urandom_range(0, 7);
        if (r < 5) begin
            return CNT_W'(lanes);
        end else if (r < 7) begin
            return CNT_W'($urandom_range(0, lanes));
        end
        return CNT_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [WORD_W-1:0] edge_b();
        case ($urandom_range(0, 3))
            0: return {8{8'h80}};
            1: return {8{8'h7F}};
            2: return {8{8'h88}};
            default: return {8{8'h77}};
        endcase
    endfunction

    task automatic add_pair(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                            input logic [CNT_W-1:0] cnt, input logic last);
        t_operand_pair p;
        p.a    = a;
        p.b    = b;
        p.cnt  = cnt;
        p.last = last;
        p.gap  = draw_wait(tx_mode);
        pairs_to_send.push_back(p);
    endtask

    task automatic drain();
        while (pairs_to_send.size() != 0 || tx_busy || sums_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_format(input t_fmt f);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ELEMENT_FORMAT;
        pwdata  <= DATA_W'(f);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        fmt_cfg = f;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(f)) begin
            $error("element_format readback: expected %0d, got %0d", f, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_vectors(input int n_items);
        int left;
        int len;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, 12);
                if (len > left) len = left;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        a = '1;
                        b = edge_b();
                    end else begin
                        a = rand_word();
                        b = rand_word();
                    end
                    add_pair(a, b, pick_count(fmt_cfg), k == len - 1);
                end
                left -= len;
            end else begin
                add_pair(rand_word(), rand_word(), CNT_W'($urandom_range(0, 31)),
                         1'($urandom_range(0, 1)));
                left--;
            end
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_operand_pair cur;
        int            gap_left;
        if (offering && in_taken) begin
            offering = 1'b0;
            tx_busy  = 1'b0;
        end
        if (!tx_busy && pairs_to_send.size() != 0) begin
            cur      = pairs_to_send.pop_front();
            gap_left = cur.gap;
            tx_busy  = 1'b1;
        end
        if (tx_busy && !offering) begin
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                offering = 1'b1;
                i_a_word        <= cur.a;
                i_b_word        <= cur.b;
                i_element_count <= cur.cnt;
                i_is_last       <= cur.last;
            end
        end
        i_in_valid <= offering;
    end

    // result receiver
    always @(negedge i_clk) begin
        int hold_seen;
        int hold_left;
        int stall_left;
        if (hold_seen != hold_asks) begin
            hold_seen++;
            hold_left = LONG_HOLD;
        end
        if (out_taken) stall_left = draw_wait(rx_mode);
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        longint expd;
        in_taken  <= i_in_valid && o_in_ready;
        out_taken <= o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (sums_due.size() == 0) begin
                    $error("dot_sum: unexpected transaction, got %0d", o_dot_sum);
                    errors++;
                end else begin
                    expd = sums_due.pop_front();
                    if (o_dot_sum !== expd) begin
                        $error("dot_sum: expected %0d, got %0d", expd, o_dot_sum);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                vector_sum = vector_sum + pair_dot(i_a_word, i_b_word, i_element_count, fmt_cfg);
                if (i_is_last) begin
                    sums_due.push_back(vector_sum);
                    vector_sum = 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_fmt f;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // byte lanes: extremes, clamping, zero count, upper bytes masked by count
        set_format(FMT_BYTE);
        add_pair('1, {8{8'h80}}, 5'd8, 1'b1);
        add_pair('1, {8{8'h7F}}, 5'd8, 1'b1);
        add_pair('0, '1, 5'd8, 1'b1);
        add_pair('1, '1, 5'd0, 1'b1);
        add_pair(rand_word(), rand_word(), 5'd31, 1'b1);
        add_pair(rand_word(), rand_word(), 5'd9, 1'b1);
        add_pair(64'hFFFF_FFFF_FF00_00FF, 64'h8080_8080_8000_0081, 5'd1, 1'b1);
        add_pair('1, '1, 5'd5, 1'b1);
        add_pair('1, {8{8'h80}}, 5'd8, 1'b0);
        add_pair('1, {8{8'h80}}, 5'd16, 1'b0);
        add_pair(rand_word(), rand_word(), 5'd3, 1'b1);
        add_pair(rand_word(), rand_word(), 5'd8, 1'b0);
        drain();

        // nibble lanes; the open vector above carries over the format change
        set_format(FMT_NIBBLE);
        add_pair('1, {8{8'h88}}, 5'd16, 1'b1);
        add_pair('1, {8{8'h77}}, 5'd16, 1'b1);
        add_pair(64'h0000_0000_0000_00FF, 64'h0000_0000_0000_00F8, 5'd1, 1'b1);
        add_pair('1, {8{8'h8F}}, 5'd15, 1'b1);
        add_pair(rand_word(), rand_word(), 5'd17, 1'b1);
        add_pair(rand_word(), rand_word(), 5'd31, 1'b1);
        add_pair('1, '1, 5'd0, 1'b1);
        add_pair({8{8'h0F}}, {8{8'h7F}}, 5'd16, 1'b0);
        add_pair(rand_word(), rand_word(), 5'd16, 1'b1);
        add_pair(rand_word(), rand_word(), 5'd9, 1'b0);
        drain();

        for (int p = 0; p < 6; p++) begin
            f = (p % 2 == 0) ? FMT_BYTE : FMT_NIBBLE;
            set_format(f);
            tx_mode = p % 3;
            rx_mode = (p + 1) % 3;
            if (p == 3) begin
                tx_mode = 0;
                hold_asks++;
            end
            random_vectors(RANDOM_ITEMS);
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/idpa_pkg.sv
rtl/core/idpa_front.sv
rtl/core/idpa_queue.sv
rtl/core/idpa_back.sv
rtl/core/int8_int4_dot_product_accumulator.sv
sim/int8_int4_dot_product_accumulator_tb.sv
